// File: src/mtg_pkg.sv
// Shared types, constants and word functions for the MT19937 generator core.
// No dependencies; used by mtg_state_ram and mersenne_twister_generator_core.
package mtg_pkg;

    // State array geometry
    localparam int STATE_WORDS  = 624;
    localparam int SHIFT_OFFSET = 397;
    localparam int WORD_W       = 32;
    localparam int IDX_W        = $clog2(STATE_WORDS);

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(STATE_WORDS - 1);
    localparam logic [IDX_W-1:0] FAR_STEP  = IDX_W'(SHIFT_OFFSET);
    localparam logic [IDX_W-1:0] FAR_WRAP  = IDX_W'(STATE_WORDS - SHIFT_OFFSET);

    // Algorithm constants
    localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
    localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;

    // Item kind carried on s_tuser
    typedef enum logic {
        OP_DRAW   = 1'b0,
        OP_RESEED = 1'b1
    } op_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_MUL,
        ST_SEED_ADD,
        ST_DRAW_RD,
        ST_DRAW_WR
    } mtg_state_t;

    // State memory write request
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [WORD_W-1:0] data;
    } ram_wr_t;

    // New word k from old word k (cur), word k+1 (nxt) and word k+397 (far)
    function automatic logic [WORD_W-1:0] twist_word(
        input logic [WORD_W-1:0] cur,
        input logic [WORD_W-1:0] nxt,
        input logic [WORD_W-1:0] far
    );
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] v;
        y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
        v = far ^ (y >> 1);
        if (y[0]) begin
            v = v ^ TWIST_MATRIX;
        end
        return v;
    endfunction

    // Output tempering
    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// File: src/mersenne_twister_generator_core.sv
// MT19937 generator core. A draw item is accepted in idle; ST_DRAW_RD then
// reads words p+1 and p+397 (mod 624) from the dual-read state memory, and
// ST_DRAW_WR twists word p in place, writes it back and registers the tempered
// result, which then shows on m_tvalid. ST_DRAW_WR stalls while the output
// register holds a word the receiver is not taking. The twist is done lazily,
// one word per draw, so there is no separate whole-state pass. A reseed item
// writes the seed as word 0 and then runs the seed recurrence for words 1 to
// 623, each through a registered 32x32 multiply, then an add and write. A draw
// that arrives before any seeding first runs that same seeding with 5489 and
// then the draw. s_tready is high only while the core is idle; a finished result
// waits in the output register while the next item is accepted.
// Depends on mtg_pkg and mtg_state_ram.
module mersenne_twister_generator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] seed
    input  logic [0:0]  s_tuser,   // [0] operation (0 draw, 1 reseed)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] random_word
);
    import mtg_pkg::*;

    mtg_state_t         state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic               seeded_reg, seeded_next;
    logic               pend_reg, pend_next;
    logic [WORD_W-1:0]  prev_reg, prev_next;
    logic [WORD_W-1:0]  prod_reg, prod_next;
    logic [WORD_W-1:0]  cache_reg, cache_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [WORD_W-1:0]  m_tdata_reg, m_tdata_next;

    ram_wr_t            ram_wr;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr_next;
    logic [IDX_W-1:0]   rd_addr_far;
    logic [WORD_W-1:0]  rd_data_next;
    logic [WORD_W-1:0]  rd_data_far;
    logic [WORD_W-1:0]  seed_word;
    logic [WORD_W-1:0]  seed_step;
    logic [WORD_W-1:0]  twisted;
    logic               in_fire;
    logic               out_free;

    mtg_state_ram u_ram (
        .aclk      (aclk),
        .wr        (ram_wr),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_next),
        .rd_addr_b (rd_addr_far),
        .rd_data_a (rd_data_next),
        .rd_data_b (rd_data_far)
    );

    // neighbor addresses of the current position, wrapped
    assign rd_addr_next = (pos_reg == LAST_IDX) ? '0 : pos_reg + IDX_W'(1);
    assign rd_addr_far  = (pos_reg >= FAR_WRAP) ? pos_reg - FAR_WRAP : pos_reg + FAR_STEP;

    // seed selection: zero seed and unseeded draws use the default
    always_comb begin
        if (s_tuser[0] == OP_RESEED && s_tdata != '0) begin
            seed_word = s_tdata;
        end else begin
            seed_word = DEFAULT_SEED;
        end
    end

    assign seed_step = prod_reg + WORD_W'(idx_reg);
    assign twisted   = twist_word(cache_reg, rd_data_next, rd_data_far);
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // sequencer: next state and datapath controls
    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        seeded_next   = seeded_reg;
        pend_next     = pend_reg;
        prev_next     = prev_reg;
        prod_next     = prod_reg;
        cache_next    = cache_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        ram_wr        = '0;
        rd_en         = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_tuser[0] == OP_RESEED || !seeded_reg) begin
                        // word 0 is the seed itself; it also primes the cache
                        ram_wr.en   = 1'b1;
                        ram_wr.addr = '0;
                        ram_wr.data = seed_word;
                        prev_next   = seed_word;
                        cache_next  = seed_word;
                        idx_next    = IDX_W'(1);
                        pend_next   = (s_tuser[0] == OP_DRAW);
                        state_next  = ST_SEED_MUL;
                    end else begin
                        state_next = ST_DRAW_RD;
                    end
                end
            end
            ST_SEED_MUL: begin
                prod_next  = SEED_MULT * (prev_reg ^ (prev_reg >> 30));
                state_next = ST_SEED_ADD;
            end
            ST_SEED_ADD: begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = idx_reg;
                ram_wr.data = seed_step;
                prev_next   = seed_step;
                if (idx_reg == LAST_IDX) begin
                    seeded_next = 1'b1;
                    pos_next    = '0;
                    pend_next   = 1'b0;
                    state_next  = pend_reg ? ST_DRAW_RD : ST_IDLE;
                end else begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_SEED_MUL;
                end
            end
            ST_DRAW_RD: begin
                rd_en      = 1'b1;
                state_next = ST_DRAW_WR;
            end
            ST_DRAW_WR: begin
                // twist word p in place and hand out its tempered value
                if (out_free) begin
                    ram_wr.en     = 1'b1;
                    ram_wr.addr   = pos_reg;
                    ram_wr.data   = twisted;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = temper(twisted);
                    cache_next    = rd_data_next;
                    pos_next      = rd_addr_next;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            seeded_reg   <= 1'b0;
            pend_reg     <= 1'b0;
            pos_reg      <= '0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            seeded_reg   <= seeded_next;
            pend_reg     <= pend_next;
            pos_reg      <= pos_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        prev_reg    <= prev_next;
        prod_reg    <= prod_next;
        cache_reg   <= cache_next;
        m_tdata_reg <= m_tdata_next;
    end

    // position stays inside the state array
    assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= LAST_IDX)
        else $error("draw position out of range");

    // neighbor reads never hit the word being twisted
    assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> (rd_addr_next != pos_reg && rd_addr_far != pos_reg))
        else $error("twist read overlaps write position");

    // a draw is only completed on a seeded state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAW_RD || state_reg == ST_DRAW_WR) |-> seeded_reg)
        else $error("draw on unseeded state");

    // a result appears only after a twist/write cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_DRAW_WR))
        else $error("result without draw");

endmodule

// File: src/mtg_state_ram.sv
// State word memory: one write port, two registered read ports.
// Depends on mtg_pkg for geometry and the write request struct.
module mtg_state_ram (
    input  logic                          aclk,
    input  mtg_pkg::ram_wr_t              wr,
    input  logic                          rd_en,
    input  logic [mtg_pkg::IDX_W-1:0]     rd_addr_a,
    input  logic [mtg_pkg::IDX_W-1:0]     rd_addr_b,
    output logic [mtg_pkg::WORD_W-1:0]    rd_data_a,
    output logic [mtg_pkg::WORD_W-1:0]    rd_data_b
);
    import mtg_pkg::*;

    logic [WORD_W-1:0] mem [STATE_WORDS];

    // write port
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read ports, data held while not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule
